### hw/rtl/dple_pkg.sv
// Shared codes, types and constants of the proof line encoder.
package dple_pkg;

    // Default widths and depths
    localparam int VAR_BITS_DEF   = 30;
    localparam int CMD_DEPTH_DEF  = 4;

    // Input function codes
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_DEL   = 2'd1;
    localparam logic [1:0] FUNC_EMPTY = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Line header codes
    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_ADD  = 2'd1;
    localparam logic [1:0] HDR_DEL  = 2'd2;

    // Register map
    localparam int          PADDR_W       = 3;
    localparam logic        REG_TEXT_MODE = 1'b0;

    // Characters
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Divide by ten: q = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v below 2**32
    localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          RADIX       = 10;

    // Control half of one queued command
    typedef struct packed {
        logic       is_empty;
        logic       text;
        logic [1:0] hdr;
        logic       neg;
        logic       last;
    } t_ctl;

    // Largest decimal digit count of a value of the given bit width
    function automatic int dec_digits(input int bits);
        longint v;
        int     n;
        v = (longint'(1) << bits) - longint'(1);
        n = 0;
        while (v != 0) begin
            v = v / RADIX;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

### hw/rtl/drat_proof_line_encoder.sv
// Top level of the proof line encoder: configuration port, front end, queue, back end.
//
// The encoder takes one literal per input transfer and sends the proof stream
// one byte per output transfer, with o_last_byte marking the final byte that a
// literal causes. Text mode (register 0, bit 0, at paddr 0) selects decimal
// lines; the mode is sampled per literal as it is accepted. The front end
// classifies each literal into a command (header, sign, value, terminator) and
// queues it; an unused function code is accepted and dropped with no output.
// The back end sends one byte per cycle while the output is taken, except while it
// waits for decimal digits. A literal's bytes are, in binary mode, the header byte,
// one byte per 7-bit group of 2*var+sign and the line terminator; in text mode
// the header, the sign, the digits, the space and the terminator, with a wait
// state before the digits. The decimal digits come from a divide-by-ten
// unit, one digit per cycle, that starts as the literal is loaded and runs under
// the header and sign bytes. The command queue lets the front end keep accepting
// while the back end works through a long literal or the output stalls.
module drat_proof_line_encoder #(
    parameter int VAR_BITS  = dple_pkg::VAR_BITS_DEF,
    parameter int CMD_DEPTH = dple_pkg::CMD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dple_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // literal input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [VAR_BITS-1:0]           i_mapped_var,
    input  logic                          i_negative,
    input  logic                          i_last_literal,
    // byte output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_byte
);
    import dple_pkg::*;

    localparam int CMD_W = $bits(t_ctl) + VAR_BITS;

    logic                r_text_mode;
    logic                reg_sel;
    logic                push;
    logic                full;
    logic                q_valid;
    logic                pop;
    t_ctl                f_ctl;
    t_ctl                q_ctl;
    logic [VAR_BITS-1:0] f_var;
    logic [VAR_BITS-1:0] q_var;
    logic [CMD_W-1:0]    q_data;

    // The register index is the word address; only the mode register exists
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_TEXT_MODE);
    assign prdata  = reg_sel ? {31'b0, r_text_mode} : 32'b0;

    // Write on the access cycle of a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_text_mode <= pwdata[0];
        end
    end

    dple_front #(
        .VAR_BITS (VAR_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_mode    (r_text_mode),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_mapped_var   (i_mapped_var),
        .i_negative     (i_negative),
        .i_last_literal (i_last_literal),
        .i_full         (full),
        .o_push         (push),
        .o_ctl          (f_ctl),
        .o_var          (f_var)
    );

    // Hold commands between the two halves
    dple_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_var}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_ctl = q_data[CMD_W-1:VAR_BITS];
    assign q_var = q_data[VAR_BITS-1:0];

    dple_back #(
        .VAR_BITS (VAR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_ctl       (q_ctl),
        .i_var       (q_var),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

### hw/rtl/dple_front.sv
// Front end: accepts input transfers, tracks the open line, builds commands.
module dple_front #(
    parameter int VAR_BITS = dple_pkg::VAR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_text_mode,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic [VAR_BITS-1:0] i_mapped_var,
    input  logic                i_negative,
    input  logic                i_last_literal,
    input  logic                i_full,
    output logic                o_push,
    output dple_pkg::t_ctl      o_ctl,
    output logic [VAR_BITS-1:0] o_var
);
    import dple_pkg::*;

    logic r_in_line;
    logic n_in_line;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (i_func != FUNC_NONE);
    assign o_var   = i_mapped_var;

    always_comb begin
        o_ctl.is_empty = (i_func == FUNC_EMPTY);
        o_ctl.text     = i_text_mode;
        o_ctl.neg      = i_negative;
        o_ctl.last     = i_last_literal;
        o_ctl.hdr      = HDR_NONE;
        n_in_line      = r_in_line;
        case (i_func)
            FUNC_EMPTY: begin
                // binary empty clause opens with 'a'; text has no header
                o_ctl.hdr = i_text_mode ? HDR_NONE : HDR_ADD;
                n_in_line = 1'b0;
            end
            FUNC_ADD: begin
                if (!r_in_line && !i_text_mode) begin
                    o_ctl.hdr = HDR_ADD;
                end
                n_in_line = !i_last_literal;
            end
            FUNC_DEL: begin
                if (!r_in_line) begin
                    o_ctl.hdr = HDR_DEL;
                end
                n_in_line = !i_last_literal;
            end
            default: begin
                n_in_line = r_in_line;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_line <= 1'b0;
        end else if (accept) begin
            r_in_line <= n_in_line;
        end
    end

endmodule

### hw/rtl/dple_fifo.sv
// Short command queue between the front and back ends.
module dple_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dple_pkg::CMD_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/dple_dec.sv
// Binary to decimal digits, one digit per cycle, low digit first.
module dple_dec #(
    parameter int VAR_BITS = dple_pkg::VAR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [VAR_BITS-1:0] i_value,
    input  logic [$clog2(dple_pkg::dec_digits(VAR_BITS))-1:0] i_rd_idx,
    output logic                o_done,
    output logic [$clog2(dple_pkg::dec_digits(VAR_BITS)+1)-1:0] o_count,
    output logic [3:0]          o_digit
);
    import dple_pkg::*;

    localparam int MAX_DIG = dec_digits(VAR_BITS);
    localparam int IDX_W   = $clog2(MAX_DIG);
    localparam int CNT_W   = $clog2(MAX_DIG + 1);
    localparam int PROD_W  = VAR_BITS + 32;

    logic [VAR_BITS-1:0] r_v;
    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [3:0]          r_dig [MAX_DIG];
    logic [PROD_W-1:0]   prod;
    logic [VAR_BITS-1:0] quot;
    logic [3:0]          q10_lo;
    logic [3:0]          rem;

    assign prod   = PROD_W'(r_v) * PROD_W'(DIV10_MUL);
    assign quot   = VAR_BITS'(prod >> DIV10_SHIFT);
    // only the low nibble of q*10 is needed for the remainder
    assign q10_lo = 4'(quot << 3) + 4'(quot << 1);
    assign rem    = r_v[3:0] - q10_lo;

    assign o_done  = !r_busy;
    assign o_count = r_cnt;
    assign o_digit = r_dig[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_dig[r_cnt[IDX_W-1:0]] <= rem;
            r_v                     <= quot;
        end else if (i_start) begin
            r_v <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_value != '0);
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (quot == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/dple_back.sv
// Back end: walks one command at a time and sends its bytes.
module dple_back #(
    parameter int VAR_BITS = dple_pkg::VAR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  dple_pkg::t_ctl      i_ctl,
    input  logic [VAR_BITS-1:0] i_var,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last_byte
);
    import dple_pkg::*;

    localparam int MAX_DIG = dec_digits(VAR_BITS);
    localparam int IDX_W   = $clog2(MAX_DIG);
    localparam int CNT_W   = $clog2(MAX_DIG + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HDR   = 4'd1;
    localparam logic [3:0] S_HSP   = 4'd2;
    localparam logic [3:0] S_SIGN  = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_DIGIT = 4'd5;
    localparam logic [3:0] S_SPACE = 4'd6;
    localparam logic [3:0] S_ZERO  = 4'd7;
    localparam logic [3:0] S_NL    = 4'd8;
    localparam logic [3:0] S_BIN   = 4'd9;
    localparam logic [3:0] S_NUL   = 4'd10;

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    t_ctl                r_ctl;
    logic [VAR_BITS:0]   r_code;
    logic [IDX_W-1:0]    r_idx;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic                slot_free;
    logic                emit;
    logic                fin;
    logic [7:0]          byte_val;
    logic [3:0]          first_state;
    logic                more;
    logic                load;
    logic                dec_done;
    logic [CNT_W-1:0]    dec_count;
    logic [3:0]          dec_digit;

    dple_dec #(
        .VAR_BITS (VAR_BITS)
    ) u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (load),
        .i_value  (i_var),
        .i_rd_idx (r_idx),
        .o_done   (dec_done),
        .o_count  (dec_count),
        .o_digit  (dec_digit)
    );

    assign slot_free = !r_out_valid || i_ready;
    assign more      = |r_code[VAR_BITS:7];

    // Entry state of the command at the queue head
    always_comb begin
        if (i_ctl.hdr != HDR_NONE) begin
            first_state = S_HDR;
        end else if (i_ctl.is_empty) begin
            first_state = S_ZERO;
        end else if (i_ctl.text) begin
            first_state = i_ctl.neg ? S_SIGN : S_WAIT;
        end else begin
            first_state = S_BIN;
        end
    end

    always_comb begin
        emit     = 1'b1;
        fin      = 1'b0;
        byte_val = CH_NUL;
        n_state  = r_state;
        case (r_state)
            S_HDR: begin
                byte_val = (r_ctl.hdr == HDR_ADD) ? CH_A : CH_D;
                if (r_ctl.text) begin
                    n_state = S_HSP;
                end else begin
                    n_state = r_ctl.is_empty ? S_NUL : S_BIN;
                end
            end
            S_HSP: begin
                byte_val = CH_SPACE;
                n_state  = r_ctl.neg ? S_SIGN : S_WAIT;
            end
            S_SIGN: begin
                byte_val = CH_MINUS;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                emit = 1'b0;
                if (dec_done) begin
                    n_state = (dec_count != '0) ? S_DIGIT : S_SPACE;
                end
            end
            S_DIGIT: begin
                byte_val = CH_ZERO + {4'b0, dec_digit};
                n_state  = (r_idx == '0) ? S_SPACE : S_DIGIT;
            end
            S_SPACE: begin
                byte_val = CH_SPACE;
                n_state  = S_ZERO;
                fin      = !r_ctl.last;
            end
            S_ZERO: begin
                byte_val = CH_ZERO;
                n_state  = S_NL;
                fin      = r_ctl.is_empty;
            end
            S_NL: begin
                byte_val = CH_NL;
                fin      = 1'b1;
            end
            S_BIN: begin
                byte_val = {more, r_code[6:0]};
                n_state  = more ? S_BIN : S_NUL;
                fin      = !more && !r_ctl.last;
            end
            S_NUL: begin
                byte_val = CH_NUL;
                fin      = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Take the next command when idle or as the current one sends its final byte
    assign load  = i_cmd_valid &&
                   ((r_state == S_IDLE) || (emit && slot_free && fin));
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (load) begin
            r_state <= first_state;
        end else if (emit && slot_free) begin
            r_state <= fin ? S_IDLE : n_state;
        end else if (!emit) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ctl  <= i_ctl;
            r_code <= {i_var, i_ctl.neg};
        end else begin
            if ((r_state == S_BIN) && slot_free && more) begin
                r_code <= r_code >> 7;
            end
            if ((r_state == S_WAIT) && dec_done) begin
                r_idx <= IDX_W'(dec_count - 1'b1);
            end else if ((r_state == S_DIGIT) && slot_free && (r_idx != '0)) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && emit) begin
            r_out_byte <= byte_val;
            r_out_last <= fin;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

### tb/sv/dple_tb_pkg.sv
// Byte-stream predictor and scoreboard for the proof line encoder testbench.
package dple_tb_pkg;

    import dple_pkg::*;

    localparam int VBITS = VAR_BITS_DEF;

    typedef struct {
        logic [7:0] data;
        logic       tail;
    } t_proof_byte;

    class t_proof_board;
        t_proof_byte expected_bytes[$];
        bit          text_mode;
        bit          line_open;
        int unsigned mismatches;

        function new();
            text_mode  = 1'b0;
            line_open  = 1'b0;
            mismatches = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            t_proof_byte pb;
            pb.data = b;
            pb.tail = 1'b0;
            expected_bytes.push_back(pb);
        endfunction

        // Work out the bytes one accepted literal causes and queue them.
        function void note_literal(logic [1:0] func, logic [VBITS-1:0] var_num,
                                   logic neg, logic last);
            logic [VBITS:0]   code;
            logic [VBITS-1:0] rest;
            logic [7:0]       digits[$];
            if (func == FUNC_NONE)
                return;
            if (func == FUNC_EMPTY) begin
                if (text_mode) begin
                    push_byte(CH_ZERO);
                end else begin
                    push_byte(CH_A);
                    push_byte(CH_NUL);
                end
                line_open = 1'b0;
            end else begin
                if (!line_open) begin
                    if (text_mode) begin
                        if (func == FUNC_DEL) begin
                            push_byte(CH_D);
                            push_byte(CH_SPACE);
                        end
                    end else begin
                        push_byte(func == FUNC_DEL ? CH_D : CH_A);
                    end
                    line_open = 1'b1;
                end
                if (text_mode) begin
                    if (neg)
                        push_byte(CH_MINUS);
                    rest = var_num;
                    while (rest != 0) begin
                        digits.push_front(CH_ZERO + 8'(rest % RADIX));
                        rest = rest / RADIX;
                    end
                    foreach (digits[k])
                        push_byte(digits[k]);
                    push_byte(CH_SPACE);
                    if (last) begin
                        push_byte(CH_ZERO);
                        push_byte(CH_NL);
                    end
                end else begin
                    code = {var_num, neg};
                    while (code > 127) begin
                        push_byte({1'b1, code[6:0]});
                        code = code >> 7;
                    end
                    push_byte(code[7:0]);
                    if (last)
                        push_byte(CH_NUL);
                end
                if (last)
                    line_open = 1'b0;
            end
            expected_bytes[expected_bytes.size() - 1].tail = 1'b1;
        endfunction

        function void check_byte(logic [7:0] data, logic tail);
            t_proof_byte want;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: no byte expected, actual %h", data);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                $error("out_byte: expected %h, actual %h", want.data, data);
                mismatches++;
            end
            if (tail !== want.tail) begin
                $error("last_byte: expected %b, actual %b", want.tail, tail);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### tb/sv/drat_proof_line_encoder_tb.sv
// Testbench top for the proof line encoder: stimulus, handshakes and the final verdict.
module drat_proof_line_encoder_tb;

    import dple_pkg::*;
    import dple_tb_pkg::*;

    // cycles to let the block settle once the last expected byte is out
    localparam int SETTLE = 32;
    localparam int PHASE_ITEMS = 36;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_func = FUNC_ADD;
    logic [VBITS-1:0]      i_mapped_var = '0;
    logic                  i_negative = 1'b0;
    logic                  i_last_literal = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_last_byte;

    int unsigned           send_idle = 0;
    int unsigned           recv_idle = 0;
    int unsigned           items_sent = 0;
    t_proof_board          board;

    drat_proof_line_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_mapped_var   (i_mapped_var),
        .i_negative     (i_negative),
        .i_last_literal (i_last_literal),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver back-pressure: drop ready at random, at the current idle rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Observe both channels at the edge. Note the literal first so that a
    // same-cycle byte can never overtake its own prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.note_literal(i_func, i_mapped_var, i_negative, i_last_literal);
            if (o_valid && i_ready)
                board.check_byte(o_out_byte, o_last_byte);
        end
    end

    // Hold valid and payload until the transfer happens. Drop valid only for
    // an idle gap, so valid is never lowered and raised in the same step.
    task automatic send_literal(input logic [1:0] func, input logic [VBITS-1:0] var_num,
                                input logic neg, input logic last);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= func;
        i_mapped_var   <= var_num;
        i_negative     <= neg;
        i_last_literal <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted byte has come out, then let
    // the block settle. Wait one edge first so the last transfer is noted.
    task automatic wait_drained(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase with penable high.
    task automatic write_text_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TEXT_MODE, 2'b00};
        pwdata  <= {31'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.text_mode = mode;
    endtask

    // Short and mid-size variables, with zero, full-width and all-ones too.
    function automatic logic [VBITS-1:0] pick_var();
        case ($urandom_range(5))
            0: return VBITS'($urandom_range(9));
            1: return VBITS'($urandom_range(10, 999));
            2: return VBITS'($urandom_range(1000, 16383));
            3: return '1;
            default: return VBITS'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned phase_start;
        int unsigned roll;
        int unsigned line_len;
        logic [1:0]  line_kind;

        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, binary lines first.
        write_text_mode(1'b0);
        send_literal(FUNC_ADD,   VBITS'(1),  1'b0, 1'b0);
        // later literal of a line carries another func: kind stays add
        send_literal(FUNC_DEL,   '1,         1'b1, 1'b1);
        send_literal(FUNC_DEL,   '0,         1'b1, 1'b1);
        send_literal(FUNC_NONE,  '1,         1'b1, 1'b1);
        send_literal(FUNC_ADD,   VBITS'(63), 1'b0, 1'b0);
        // empty clause drops the open line without a terminator
        send_literal(FUNC_EMPTY, '1,         1'b1, 1'b0);
        send_literal(FUNC_EMPTY, '0,         1'b0, 1'b1);
        send_literal(FUNC_ADD,   VBITS'(64), 1'b0, 1'b1);
        send_literal(FUNC_ADD,   VBITS'(5),  1'b1, 1'b0);

        // Switch to text with the line still open: no second header.
        wait_drained(SETTLE);
        write_text_mode(1'b1);
        send_literal(FUNC_DEL,   VBITS'(7),  1'b0, 1'b1);
        send_literal(FUNC_DEL,   '1,         1'b0, 1'b0);
        send_literal(FUNC_ADD,   '0,         1'b1, 1'b1);
        send_literal(FUNC_ADD,   VBITS'(9),  1'b0, 1'b1);
        send_literal(FUNC_ADD,   VBITS'(10), 1'b1, 1'b1);
        send_literal(FUNC_ADD,   '0,         1'b0, 1'b1);
        send_literal(FUNC_EMPTY, '0,         1'b0, 1'b0);
        send_literal(FUNC_ADD,   VBITS'(3),  1'b0, 1'b0);
        send_literal(FUNC_EMPTY, VBITS'(3),  1'b1, 1'b1);
        send_literal(FUNC_NONE,  '0,         1'b0, 1'b0);
        // longest line: delete header, sign, ten digits, space, terminator
        send_literal(FUNC_DEL,   '1,         1'b1, 1'b1);
        send_literal(FUNC_DEL,   VBITS'(1000000000), 1'b0, 1'b1);

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 31;
                    recv_idle = 86;
                end
                1: begin
                    send_idle = 86;
                    recv_idle = 31;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            wait_drained(SETTLE);
            write_text_mode(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom));
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // halfway, if the count lands on it: pause the sender until everything is out, pick a random mode
                if (items_sent - phase_start >= PHASE_ITEMS / 2
                        && items_sent - phase_start < PHASE_ITEMS / 2 + 1) begin
                    wait_drained(SETTLE);
                    write_text_mode(1'($urandom));
                end
                roll = $urandom_range(99);
                if (roll < 8) begin
                    send_literal(FUNC_NONE, VBITS'($urandom), 1'($urandom), 1'($urandom));
                end else if (roll < 14) begin
                    send_literal(FUNC_EMPTY, pick_var(), 1'($urandom), 1'($urandom));
                end else if (roll < 22) begin
                    // broken sequence: any func, any end marker
                    send_literal(2'($urandom), pick_var(), 1'($urandom), 1'($urandom));
                end else begin
                    line_kind = $urandom_range(1) ? FUNC_DEL : FUNC_ADD;
                    line_len  = $urandom_range(1, 4);
                    for (int k = 0; k < line_len; k++) begin
                        send_literal(k == 0 ? line_kind : 2'($urandom_range(1)),
                                     pick_var(), 1'($urandom), k == line_len - 1);
                    end
                end
            end
        end

        wait_drained(SETTLE);
        if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/dple_pkg.sv
hw/rtl/dple_front.sv
hw/rtl/dple_fifo.sv
hw/rtl/dple_dec.sv
hw/rtl/dple_back.sv
hw/rtl/drat_proof_line_encoder.sv
tb/sv/dple_tb_pkg.sv
tb/sv/drat_proof_line_encoder_tb.sv
